[sv/nav_string_frame_builder_core_defines.svh]
`ifndef NAV_STRING_FRAME_BUILDER_CORE_DEFINES_SVH
`define NAV_STRING_FRAME_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define NSFB_ASSERT_IMPL(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define NSFB_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[sv/nsfb_pkg.sv]
package nsfb_pkg;

    localparam int TIME_W    = 30;
    localparam int WORD_W    = 32;
    localparam int SLOT_W    = 5;
    localparam int STR_W     = 4;
    localparam int WORDN_W   = 2;
    localparam int SAT_W     = 5;
    localparam int FRAME_W   = 3;
    localparam int ROW_W     = 7;

    localparam int STRING_MS        = 2000;
    localparam int EPH_STRINGS      = 4;
    localparam int WORDS_PER_STRING = 3;

    localparam int W0_BITS    = 21;
    localparam int DATA_W     = 85;
    localparam int CHECK_BITS = 7;
    localparam int PAD_BITS   = 7;
    localparam int NAV_BITS   = 100;
    localparam int HEAD_W     = 36;
    localparam int TAIL_W     = 64;

    typedef enum logic [0:0] {
        MODE_WRITE    = 1'b0,
        MODE_GENERATE = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_STRING  = 2'd0,
        ST_BAD_SAT = 2'd1,
        ST_WRITTEN = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef struct packed {
        mode_t               mode;
        logic                to_almanac;
        logic [SLOT_W-1:0]   slot;
        logic [STR_W-1:0]    string_number;
        logic [WORDN_W-1:0]  word_number;
        logic [WORD_W-1:0]   word_value;
        logic [SAT_W-1:0]    satellite;
    } item_t;

    // Data bit n (1-based) sits at data[DATA_W-n]; check k covers every n with bit k set.
    function automatic logic [DATA_W-1:0] check_mask(input int k);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int n = 1; n <= DATA_W; n++)
        begin
            if (((n >> k) & 1) != 0)
            begin
                m[DATA_W-n] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

[sv/nsfb_item_if.sv]
interface nsfb_item_if;
    import nsfb_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic                to_almanac;
    logic [SLOT_W-1:0]   slot;
    logic [STR_W-1:0]    string_number;
    logic [WORDN_W-1:0]  word_number;
    logic [WORD_W-1:0]   word_value;
    logic [TIME_W-1:0]   time_ms;
    logic [SAT_W-1:0]    satellite;

    modport source (
        output valid, mode, to_almanac, slot, string_number, word_number, word_value,
               time_ms, satellite,
        input  ready
    );

    modport sink (
        input  valid, mode, to_almanac, slot, string_number, word_number, word_value,
               time_ms, satellite,
        output ready
    );
endinterface

[sv/nsfb_result_if.sv]
interface nsfb_result_if;
    import nsfb_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [HEAD_W-1:0]  bits_head;
    logic [TAIL_W-1:0]  bits_tail;

    modport source (
        output valid, status, bits_head, bits_tail,
        input  ready
    );

    modport sink (
        input  valid, status, bits_head, bits_tail,
        output ready
    );
endinterface

[sv/nav_string_frame_builder_core.sv]
// Navigation string builder with Hamming-style check bits.
// item channel (valid/ready): mode 0 writes one 32-bit word into the ephemeris store
// (4 strings x 3 words per satellite) or the almanac store (STRINGS_PER_FRAME-4 strings
// x 3 words per frame). mode 1 picks a string from time_ms and satellite and sends it
// out as 100 bits: 7 check bits, 1 overall parity bit, 7 zeros, 85 data bits.
// result channel (valid/ready): one word per item, in order, with a status code.
// Throughput: one item per cycle when result.ready does not stall, set by the six-register
// pipeline (input, two divide stages, store access, read data, output) and one read port
// per word store.
// Reset: both stores are swept to zero, one row of three words per cycle, until all
// max(4*SATELLITE_COUNT, ALMANAC_FRAMES*(STRINGS_PER_FRAME-4)) rows (96 by default) are
// cleared; item.ready stays low during the sweep.
// Stall: while result.valid is high and result.ready low, the whole pipeline holds and
// item.ready drops; nothing is lost or repeated.
`include "nav_string_frame_builder_core_defines.svh"

module nav_string_frame_builder_core #(
    parameter int SATELLITE_COUNT   = 24,
    parameter int ALMANAC_FRAMES    = 5,
    parameter int STRINGS_PER_FRAME = 15
) (
    input logic           clk,
    input logic           rst_n,
    nsfb_item_if.sink     item,
    nsfb_result_if.source result
);
    import nsfb_pkg::*;

    localparam int ALM_STRINGS = STRINGS_PER_FRAME - EPH_STRINGS;
    localparam int EPH_ROWS    = SATELLITE_COUNT * EPH_STRINGS;
    localparam int ALM_ROWS    = ALMANAC_FRAMES * ALM_STRINGS;
    localparam int EPH_AW      = (EPH_ROWS > 1) ? $clog2(EPH_ROWS) : 1;
    localparam int ALM_AW      = (ALM_ROWS > 1) ? $clog2(ALM_ROWS) : 1;
    localparam int CLR_ROWS    = (EPH_ROWS > ALM_ROWS) ? EPH_ROWS : ALM_ROWS;
    localparam int CLR_W       = $clog2(CLR_ROWS + 1);
    localparam int SLOT_CW     = SLOT_W + 1;

    logic                advance;
    logic                accept;
    logic                clearing_reg;
    logic [CLR_W-1:0]    clr_cnt_reg;

    item_t               in_item;
    logic                a_valid_reg;
    item_t               a_item_reg;
    logic [TIME_W-1:0]   a_time_reg;

    logic                d_valid;
    item_t               d_item;
    logic [STR_W-1:0]    d_string;
    logic [FRAME_W-1:0]  d_frame;

    logic                wr_eph_ok;
    logic                wr_alm_ok;
    logic                sat_ok;
    logic                use_eph;
    status_t             d_status;
    logic [SAT_W-1:0]    sat_m1;
    logic [ROW_W-1:0]    eph_rd_row;
    logic [ROW_W-1:0]    alm_rd_row;
    logic [ROW_W-1:0]    eph_wr_row;
    logic [ROW_W-1:0]    alm_wr_row;
    logic                eph_we_item;
    logic                alm_we_item;

    logic [EPH_AW-1:0]   eph_waddr;
    logic [EPH_AW-1:0]   eph_raddr;
    logic [ALM_AW-1:0]   alm_waddr;
    logic [ALM_AW-1:0]   alm_raddr;
    logic [WORD_W-1:0]   wdata;
    logic [WORDS_PER_STRING-1:0] eph_we;
    logic [WORDS_PER_STRING-1:0] alm_we;
    logic [WORD_W-1:0]   eph_rdata [WORDS_PER_STRING];
    logic [WORD_W-1:0]   alm_rdata [WORDS_PER_STRING];
    logic [WORD_W-1:0]   enc_word  [WORDS_PER_STRING];

    logic                e_valid_reg;
    status_t             e_status_reg;
    logic                e_use_eph_reg;

    logic [HEAD_W-1:0]   enc_head;
    logic [TAIL_W-1:0]   enc_tail;

    logic                res_valid_reg;
    status_t             res_status_reg;
    logic [HEAD_W-1:0]   res_head_reg;
    logic [TAIL_W-1:0]   res_tail_reg;

    assign advance    = !res_valid_reg || result.ready;
    assign item.ready = advance && !clearing_reg;
    assign accept     = item.valid && item.ready;

    // store clear after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == CLR_W'(CLR_ROWS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // stage A: input register
    always_comb
    begin
        in_item.mode          = mode_t'(item.mode);
        in_item.to_almanac    = item.to_almanac;
        in_item.slot          = item.slot;
        in_item.string_number = item.string_number;
        in_item.word_number   = item.word_number;
        in_item.word_value    = item.word_value;
        in_item.satellite     = item.satellite;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg <= in_item;
            a_time_reg <= item.time_ms;
        end
    end

    // stages B..D: string and frame from time
    nsfb_slot_calc #(
        .STRINGS_PER_FRAME (STRINGS_PER_FRAME),
        .ALMANAC_FRAMES    (ALMANAC_FRAMES)
    ) u_slot_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .a_valid   (a_valid_reg),
        .a_item    (a_item_reg),
        .a_time_ms (a_time_reg),
        .d_valid   (d_valid),
        .d_item    (d_item),
        .d_string  (d_string),
        .d_frame   (d_frame)
    );

    // stage D: store access; writes and reads share this stage so order is kept
    always_comb
    begin
        wr_eph_ok = !d_item.to_almanac
                    && ({1'b0, d_item.slot} < SLOT_CW'(SATELLITE_COUNT))
                    && (d_item.string_number < STR_W'(EPH_STRINGS))
                    && (d_item.word_number < WORDN_W'(WORDS_PER_STRING));
        wr_alm_ok = d_item.to_almanac
                    && ({1'b0, d_item.slot} < SLOT_CW'(ALMANAC_FRAMES))
                    && (d_item.string_number < STR_W'(ALM_STRINGS))
                    && (d_item.word_number < WORDN_W'(WORDS_PER_STRING));
        sat_ok    = (d_item.satellite != '0)
                    && ({1'b0, d_item.satellite} <= SLOT_CW'(SATELLITE_COUNT));
        use_eph   = d_string < STR_W'(EPH_STRINGS);

        case (d_item.mode)
            MODE_WRITE:    d_status = (wr_eph_ok || wr_alm_ok) ? ST_WRITTEN : ST_IGNORED;
            MODE_GENERATE: d_status = sat_ok ? ST_STRING : ST_BAD_SAT;
            default:       d_status = ST_IGNORED;
        endcase

        sat_m1     = d_item.satellite - SAT_W'(1);
        eph_rd_row = ROW_W'(sat_m1) * ROW_W'(EPH_STRINGS) + ROW_W'(d_string);
        alm_rd_row = ROW_W'(d_frame) * ROW_W'(ALM_STRINGS) + ROW_W'(d_string)
                     - ROW_W'(EPH_STRINGS);
        eph_wr_row = ROW_W'(d_item.slot) * ROW_W'(EPH_STRINGS)
                     + ROW_W'(d_item.string_number);
        alm_wr_row = ROW_W'(d_item.slot) * ROW_W'(ALM_STRINGS)
                     + ROW_W'(d_item.string_number);

        eph_raddr = (sat_ok && use_eph) ? eph_rd_row[EPH_AW-1:0] : '0;
        alm_raddr = use_eph ? '0 : alm_rd_row[ALM_AW-1:0];

        eph_we_item = advance && d_valid && (d_item.mode == MODE_WRITE) && wr_eph_ok;
        alm_we_item = advance && d_valid && (d_item.mode == MODE_WRITE) && wr_alm_ok;

        eph_waddr = clearing_reg ? clr_cnt_reg[EPH_AW-1:0] : eph_wr_row[EPH_AW-1:0];
        alm_waddr = clearing_reg ? clr_cnt_reg[ALM_AW-1:0] : alm_wr_row[ALM_AW-1:0];
        wdata     = clearing_reg ? '0 : d_item.word_value;

        for (int j = 0; j < WORDS_PER_STRING; j++)
        begin
            if (clearing_reg)
            begin
                eph_we[j] = clr_cnt_reg < CLR_W'(EPH_ROWS);
                alm_we[j] = clr_cnt_reg < CLR_W'(ALM_ROWS);
            end
            else
            begin
                eph_we[j] = eph_we_item && (d_item.word_number == WORDN_W'(j));
                alm_we[j] = alm_we_item && (d_item.word_number == WORDN_W'(j));
            end
        end
    end

    for (genvar j = 0; j < WORDS_PER_STRING; j++)
    begin : g_word
        nsfb_ram #(
            .DEPTH (EPH_ROWS),
            .WIDTH (WORD_W)
        ) u_eph_ram (
            .clk   (clk),
            .we    (eph_we[j]),
            .waddr (eph_waddr),
            .wdata (wdata),
            .re    (advance),
            .raddr (eph_raddr),
            .rdata (eph_rdata[j])
        );

        nsfb_ram #(
            .DEPTH (ALM_ROWS),
            .WIDTH (WORD_W)
        ) u_alm_ram (
            .clk   (clk),
            .we    (alm_we[j]),
            .waddr (alm_waddr),
            .wdata (wdata),
            .re    (advance),
            .raddr (alm_raddr),
            .rdata (alm_rdata[j])
        );

        assign enc_word[j] = e_use_eph_reg ? eph_rdata[j] : alm_rdata[j];
    end

    // stage E: read data stands in the RAM output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            e_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e_status_reg  <= d_status;
            e_use_eph_reg <= use_eph;
        end
    end

    nsfb_encoder u_encoder (
        .word0     (enc_word[0]),
        .word1     (enc_word[1]),
        .word2     (enc_word[2]),
        .bits_head (enc_head),
        .bits_tail (enc_tail)
    );

    // stage F: output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_status_reg <= e_status_reg;
            res_head_reg   <= (e_status_reg == ST_STRING) ? enc_head : '0;
            res_tail_reg   <= (e_status_reg == ST_STRING) ? enc_tail : '0;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.status    = res_status_reg;
    assign result.bits_head = res_head_reg;
    assign result.bits_tail = res_tail_reg;

    `NSFB_ASSERT_IMPL(a_no_accept_in_clear, clearing_reg, !item.ready, "word accepted during store clear")
    `NSFB_ASSERT_NEXT(a_clear_steps, clearing_reg, !clearing_reg || (clr_cnt_reg == $past(clr_cnt_reg) + 1'b1), "clear counter skipped")
    `NSFB_ASSERT_NEXT(a_freeze_on_stall, !advance, $stable(a_valid_reg) && $stable(e_valid_reg), "pipeline moved during stall")
    `NSFB_ASSERT_IMPL(a_no_string_zero, result.valid && (result.status != ST_STRING), (result.bits_head == '0) && (result.bits_tail == '0), "non-string result carries bits")
    `NSFB_ASSERT_IMPL(a_overall_parity, result.valid && (result.status == ST_STRING), (^result.bits_head) == (^result.bits_tail), "string fails overall parity")

endmodule

[sv/nsfb_ram.sv]
module nsfb_ram #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/nsfb_slot_calc.sv]
module nsfb_slot_calc #(
    parameter int STRINGS_PER_FRAME = 15,
    parameter int ALMANAC_FRAMES    = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          a_valid,
    input  nsfb_pkg::item_t               a_item,
    input  logic [nsfb_pkg::TIME_W-1:0]   a_time_ms,
    output logic                          d_valid,
    output nsfb_pkg::item_t               d_item,
    output logic [nsfb_pkg::STR_W-1:0]    d_string,
    output logic [nsfb_pkg::FRAME_W-1:0]  d_frame
);
    import nsfb_pkg::*;

    // floor(x/D) = (x*ceil(2^(N+l)/D)) >> (N+l), l = ceil(log2 D), exact for x < 2^N
    localparam int PW   = 2 * TIME_W + 1;
    localparam int D1   = STRING_MS;
    localparam int K1   = TIME_W + $clog2(D1);
    localparam longint unsigned M1 = ((64'd1 << K1) + D1 - 1) / D1;
    localparam int Q1_W = TIME_W - $clog2(D1 + 1) + 1;

    localparam int D2   = STRING_MS * STRINGS_PER_FRAME;
    localparam int K2   = TIME_W + $clog2(D2);
    localparam longint unsigned M2 = ((64'd1 << K2) + D2 - 1) / D2;
    localparam int Q2_W = TIME_W - $clog2(D2 + 1) + 1;

    localparam int P3W  = 2 * Q2_W + 1;
    localparam int K3   = Q2_W + $clog2(ALMANAC_FRAMES);
    localparam longint unsigned M3 =
        ((64'd1 << K3) + ALMANAC_FRAMES - 1) / ALMANAC_FRAMES;
    localparam int Q3_W = Q2_W - $clog2(ALMANAC_FRAMES + 1) + 1;

    logic [PW-1:0]    prod1;
    logic [PW-1:0]    prod2;
    logic [P3W-1:0]   prod3;
    logic [Q1_W-1:0]  str_full;
    logic [Q2_W-1:0]  frame_full;

    logic             b_valid_reg;
    item_t            b_item_reg;
    logic [Q1_W-1:0]  b_q1_reg;
    logic [Q2_W-1:0]  b_q2_reg;

    logic             c_valid_reg;
    item_t            c_item_reg;
    logic [Q2_W-1:0]  c_q2_reg;
    logic [Q3_W-1:0]  c_q3_reg;
    logic [STR_W-1:0] c_string_reg;

    logic               d_valid_reg;
    item_t              d_item_reg;
    logic [STR_W-1:0]   d_string_reg;
    logic [FRAME_W-1:0] d_frame_reg;

    // stage B: string count and frame count since week start
    assign prod1 = PW'(a_time_ms) * PW'(M1);
    assign prod2 = PW'(a_time_ms) * PW'(M2);

    // stage C: string within frame, frame count divided by frame total
    assign prod3    = P3W'(b_q2_reg) * P3W'(M3);
    assign str_full = b_q1_reg - Q1_W'(b_q2_reg) * Q1_W'(STRINGS_PER_FRAME);

    // stage D: frame index
    assign frame_full = c_q2_reg - Q2_W'(c_q3_reg) * Q2_W'(ALMANAC_FRAMES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= a_valid;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_item_reg   <= a_item;
            b_q1_reg     <= prod1[K1+Q1_W-1:K1];
            b_q2_reg     <= prod2[K2+Q2_W-1:K2];

            c_item_reg   <= b_item_reg;
            c_q2_reg     <= b_q2_reg;
            c_q3_reg     <= prod3[K3+Q3_W-1:K3];
            c_string_reg <= str_full[STR_W-1:0];

            d_item_reg   <= c_item_reg;
            d_string_reg <= c_string_reg;
            d_frame_reg  <= frame_full[FRAME_W-1:0];
        end
    end

    assign d_valid  = d_valid_reg;
    assign d_item   = d_item_reg;
    assign d_string = d_string_reg;
    assign d_frame  = d_frame_reg;

endmodule

[sv/nsfb_encoder.sv]
module nsfb_encoder (
    input  logic [nsfb_pkg::WORD_W-1:0] word0,
    input  logic [nsfb_pkg::WORD_W-1:0] word1,
    input  logic [nsfb_pkg::WORD_W-1:0] word2,
    output logic [nsfb_pkg::HEAD_W-1:0] bits_head,
    output logic [nsfb_pkg::TAIL_W-1:0] bits_tail
);
    import nsfb_pkg::*;

    logic [DATA_W-1:0]     data;
    logic [CHECK_BITS-1:0] chk;
    logic                  overall;
    logic [NAV_BITS-1:0]   nav;

    always_comb
    begin
        data = {word0[W0_BITS-1:0], word1, word2};
        for (int k = 0; k < CHECK_BITS; k++)
        begin
            // p1 lands in the MSB of chk
            chk[CHECK_BITS-1-k] = ^(data & check_mask(k));
        end
        overall   = (^data) ^ (^chk);
        nav       = {chk, overall, {PAD_BITS{1'b0}}, data};
        bits_head = nav[NAV_BITS-1 -: HEAD_W];
        bits_tail = nav[TAIL_W-1:0];
    end

endmodule
